// ===== rtl/cascaded_biquad_iir_filter_defines.svh =====
// assertion helpers used by the checker of this block
`ifndef CASCADED_BIQUAD_IIR_FILTER_DEFINES_SVH
`define CASCADED_BIQUAD_IIR_FILTER_DEFINES_SVH

// consequent checked in the same cycle
`define CBQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define CBQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cbq_pkg.sv =====
package cbq_pkg;

    localparam int COEF_W           = 24;
    localparam int DATA_W           = 32;
    localparam int SAMPLE_W         = 16;
    localparam int PROD_W           = COEF_W + DATA_W;
    localparam int ACC_W            = DATA_W + 2;
    localparam int FRAC_SHIFT       = 20;
    localparam int IN_FRAC          = 8;
    localparam int CFG_DATA_W       = 31;
    localparam int CFG_IDX_W        = 1;
    localparam int NSEC_W           = 4;
    localparam int SEC_FIELD_W      = 3;
    localparam int SEL_W            = 3;
    localparam int COEF_PER_SECTION = 6;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    localparam logic [SEL_W-1:0] SEL_B0 = 3'd0;
    localparam logic [SEL_W-1:0] SEL_B1 = 3'd1;
    localparam logic [SEL_W-1:0] SEL_B2 = 3'd2;
    localparam logic [SEL_W-1:0] SEL_A0 = 3'd3;
    localparam logic [SEL_W-1:0] SEL_A1 = 3'd4;
    localparam logic [SEL_W-1:0] SEL_A2 = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SECTIONS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_LIMIT = 1'b1;

    localparam logic [NSEC_W-1:0]     NUM_SECTIONS_RESET   = 4'd1;
    localparam logic [CFG_DATA_W-1:0] OVERFLOW_LIMIT_RESET = 31'h4000_0000;

    typedef logic signed [DATA_W-1:0] sig_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        logic acc_load;
        logic acc_add;
        logic acc_sub;
    } mac_ctrl_t;

    localparam sig_t SIG_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam sig_t SIG_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam acc_t ACC_HI  = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam acc_t ACC_LO  = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    function automatic sig_t sat_acc(acc_t a);
        sig_t r;
        if (a > ACC_HI)
            r = SIG_MAX;
        else if (a < ACC_LO)
            r = SIG_MIN;
        else
            r = sig_t'(a[DATA_W-1:0]);
        return r;
    endfunction

    // magnitude of the most negative value still fits unsigned
    function automatic logic [DATA_W-1:0] magnitude(sig_t v);
        logic [DATA_W-1:0] u;
        u = v;
        return v[DATA_W-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

// ===== rtl/cbq_item_if.sv =====
interface cbq_item_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  func;
    logic signed [cbq_pkg::SAMPLE_W-1:0]   sample_in;
    logic                                  start_of_block;
    logic [cbq_pkg::SEC_FIELD_W-1:0]       coef_section;
    logic [cbq_pkg::SEL_W-1:0]             coef_select;
    logic signed [cbq_pkg::COEF_W-1:0]     coef_value;

    modport source (
        output valid, func, sample_in, start_of_block, coef_section, coef_select,
               coef_value,
        input  ready
    );

    modport sink (
        input  valid, func, sample_in, start_of_block, coef_section, coef_select,
               coef_value,
        output ready
    );
endinterface

// ===== rtl/cbq_result_if.sv =====
interface cbq_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [cbq_pkg::SAMPLE_W-1:0] sample_out;
    logic                                overflow_cleared;

    modport source (
        output valid, sample_out, overflow_cleared,
        input  ready
    );

    modport sink (
        input  valid, sample_out, overflow_cleared,
        output ready
    );
endinterface

// ===== rtl/cbq_ram.sv =====
module cbq_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/cbq_mac.sv =====
module cbq_mac (
    input  logic               clk,
    input  cbq_pkg::coef_t     coef,
    input  cbq_pkg::sig_t      sig,
    input  cbq_pkg::mac_ctrl_t ctrl,
    output cbq_pkg::sig_t      result
);
    import cbq_pkg::*;

    localparam int SH_W = PROD_W + 1 - FRAC_SHIFT;
    localparam logic signed [PROD_W:0]   ROUND_CONST = (PROD_W+1)'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [SH_W-1:0]   SH_HI = {{(SH_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SH_W-1:0]   SH_LO = {{(SH_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W:0]   rounded;
    logic signed [SH_W-1:0]   shifted;
    sig_t                     rnd_next;
    sig_t                     rnd_reg;
    acc_t                     acc_next;
    acc_t                     acc_reg;

    // round half up at 20 fraction bits, then saturate to 32 bits
    always_comb
    begin
        rounded = {prod_reg[PROD_W-1], prod_reg} + ROUND_CONST;
        shifted = rounded[PROD_W:FRAC_SHIFT];
        if (shifted > SH_HI)
            rnd_next = SIG_MAX;
        else if (shifted < SH_LO)
            rnd_next = SIG_MIN;
        else
            rnd_next = sig_t'(shifted[DATA_W-1:0]);
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_load)
            acc_next = acc_t'(rnd_reg);
        else if (ctrl.acc_add)
            acc_next = acc_reg + acc_t'(rnd_reg);
        else if (ctrl.acc_sub)
            acc_next = acc_reg - acc_t'(rnd_reg);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef * sig;
        rnd_reg  <= rnd_next;
        acc_reg  <= acc_next;
    end

    assign result = sat_acc(acc_reg);
endmodule

// ===== rtl/cascaded_biquad_iir_filter.sv =====
// Cascaded Direct Form I biquad filter. A coefficient write reaches memory in the cycle
// it is accepted. A sample runs through each section in use (num_sections clamped to
// 1..MAX_SECTIONS) on the one shared multiply, round and accumulate unit that works
// through the six products of each section in turn, fed by registered reads of the
// coefficient memory and of the section state memory. Both memories start cleared
// through per-entry and per-section valid bits, so there is no clearing pass after
// reset; the per-section bits make a start-of-block or overflow clear take effect
// at once. A result waits in an output register, and the next word is accepted while
// it waits.
module cascaded_biquad_iir_filter #(
    parameter int MAX_SECTIONS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    cbq_item_if.sink                         items,
    cbq_result_if.source                     results,
    input  logic                             cfg_we,
    input  logic [cbq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cbq_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cbq_pkg::*;

    localparam int COEF_DEPTH = MAX_SECTIONS * COEF_PER_SECTION;
    localparam int CADDR_W    = $clog2(COEF_DEPTH);
    localparam int SEC_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int ROW_W      = 4 * DATA_W;
    localparam int STEP_W     = 4;
    localparam int RND_W      = DATA_W + 1;
    localparam int Q_W        = RND_W - IN_FRAC;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [STEP_W-1:0] STEP_CHECK  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_B0 = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MUL_B1 = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MUL_B2 = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ACC_B1 = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ACC_B2 = 4'd5;
    localparam logic [STEP_W-1:0] STEP_CENTER = 4'd6;
    localparam logic [STEP_W-1:0] STEP_MUL_A0 = 4'd7;
    localparam logic [STEP_W-1:0] STEP_MUL_A1 = 4'd8;
    localparam logic [STEP_W-1:0] STEP_MUL_A2 = 4'd9;
    localparam logic [STEP_W-1:0] STEP_ACC_A1 = 4'd10;
    localparam logic [STEP_W-1:0] STEP_ACC_A2 = 4'd11;
    localparam logic [STEP_W-1:0] STEP_OUTPUT = 4'd12;

    localparam logic signed [RND_W-1:0] OUT_ROUND = RND_W'(1) <<< (IN_FRAC - 1);
    localparam logic signed [Q_W-1:0] Q_HI = {{(Q_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_LO = {{(Q_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

    logic [1:0]                  state_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [SEC_W-1:0]            sec_reg;
    logic [SEC_W-1:0]            last_sec_reg;
    logic [SEC_W-1:0]            last_sec_start;
    logic [CADDR_W-1:0]          cbase_reg;
    logic [NSEC_W-1:0]           num_sections_reg;
    logic [CFG_DATA_W-1:0]       overflow_limit_reg;
    logic [DATA_W-1:0]           peak_reg;
    logic                        flag_reg;
    logic [COEF_DEPTH-1:0]       coef_valid_reg;
    logic                        coef_ok_reg;
    logic [MAX_SECTIONS-1:0]     row_valid_reg;
    logic                        out_valid_reg;
    logic signed [SAMPLE_W-1:0]  out_sample_reg;
    logic                        out_flag_reg;

    sig_t x_reg;
    sig_t d1_reg;
    sig_t d2_reg;
    sig_t yd1_reg;
    sig_t yd2_reg;
    sig_t center_reg;

    logic                        item_acc;
    logic                        smp_start;
    logic                        cw_en;
    logic [CADDR_W-1:0]          cw_addr;
    logic [SEL_W-1:0]            coef_off;
    logic [CADDR_W-1:0]          craddr;
    logic [COEF_W-1:0]           coef_rdata;
    logic [ROW_W-1:0]            row_rdata;
    logic [ROW_W-1:0]            row_wdata;
    logic                        row_we;
    logic                        running;
    logic                        overflow;
    logic                        out_load;
    logic [DATA_W-1:0]           mac_mag;
    coef_t                       coef_op;
    sig_t                        sig_op;
    sig_t                        mac_result;
    mac_ctrl_t                   mac_ctrl;
    logic signed [RND_W-1:0]     out_rnd;
    logic signed [Q_W-1:0]       out_q;
    logic signed [SAMPLE_W-1:0]  out_sat;

    assign items.ready = (state_reg == ST_IDLE);
    assign item_acc    = items.valid && items.ready;
    assign smp_start   = item_acc && (items.func == FUNC_SAMPLE);
    assign cw_en       = item_acc && (items.func == FUNC_COEF)
                         && (int'(items.coef_section) < MAX_SECTIONS)
                         && (items.coef_select <= SEL_A2);
    assign cw_addr     = CADDR_W'(int'(items.coef_section) * COEF_PER_SECTION
                                  + int'(items.coef_select));

    assign running  = (state_reg == ST_RUN);
    assign overflow = peak_reg > {1'b0, overflow_limit_reg};
    assign row_we   = running && (step_reg == STEP_OUTPUT);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);
    assign mac_mag  = magnitude(mac_result);

    always_comb
    begin
        if (num_sections_reg == '0)
            last_sec_start = '0;
        else if (int'(num_sections_reg) > MAX_SECTIONS)
            last_sec_start = SEC_W'(MAX_SECTIONS - 1);
        else
            last_sec_start = SEC_W'(num_sections_reg - 1'b1);
    end

    // coefficient read is issued in the step before its product
    always_comb
    begin
        case (step_reg)
            STEP_CHECK:  coef_off = SEL_B0;
            STEP_MUL_B0: coef_off = SEL_B1;
            STEP_MUL_B1: coef_off = SEL_B2;
            STEP_CENTER: coef_off = SEL_A0;
            STEP_MUL_A0: coef_off = SEL_A1;
            STEP_MUL_A1: coef_off = SEL_A2;
            default:     coef_off = SEL_B0;
        endcase
        craddr = cbase_reg + CADDR_W'(coef_off);
    end

    always_comb
    begin
        case (step_reg)
            STEP_MUL_B0: sig_op = x_reg;
            STEP_MUL_B1: sig_op = d1_reg;
            STEP_MUL_B2: sig_op = d2_reg;
            STEP_MUL_A0: sig_op = center_reg;
            STEP_MUL_A1: sig_op = yd1_reg;
            STEP_MUL_A2: sig_op = yd2_reg;
            default:     sig_op = '0;
        endcase
        coef_op = coef_ok_reg ? coef_t'(coef_rdata) : '0;
    end

    always_comb
    begin
        mac_ctrl = '0;
        if (running)
        begin
            mac_ctrl.acc_load = (step_reg == STEP_MUL_B2) || (step_reg == STEP_MUL_A2);
            mac_ctrl.acc_add  = (step_reg == STEP_ACC_B1) || (step_reg == STEP_ACC_B2);
            mac_ctrl.acc_sub  = (step_reg == STEP_ACC_A1) || (step_reg == STEP_ACC_A2);
        end
    end

    assign row_wdata = {x_reg, d1_reg, mac_result, yd1_reg};

    always_comb
    begin
        out_rnd = {x_reg[DATA_W-1], x_reg} + OUT_ROUND;
        out_q   = out_rnd[RND_W-1:IN_FRAC];
        if (out_q > Q_HI)
            out_sat = SAMPLE_W'(Q_HI);
        else if (out_q < Q_LO)
            out_sat = SAMPLE_W'(Q_LO);
        else
            out_sat = out_q[SAMPLE_W-1:0];
    end

    cbq_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (cw_en),
        .waddr (cw_addr),
        .wdata (items.coef_value),
        .raddr (craddr),
        .rdata (coef_rdata)
    );

    cbq_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SECTIONS)
    ) u_state_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (sec_reg),
        .wdata (row_wdata),
        .raddr (sec_reg),
        .rdata (row_rdata)
    );

    cbq_mac u_mac (
        .clk    (clk),
        .coef   (coef_op),
        .sig    (sig_op),
        .ctrl   (mac_ctrl),
        .result (mac_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sections_reg   <= NUM_SECTIONS_RESET;
            overflow_limit_reg <= OVERFLOW_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_SECTIONS:   num_sections_reg   <= cfg_data[NSEC_W-1:0];
                CFG_OVERFLOW_LIMIT: overflow_limit_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= STEP_CHECK;
            sec_reg        <= '0;
            last_sec_reg   <= '0;
            cbase_reg      <= '0;
            peak_reg       <= '0;
            flag_reg       <= 1'b0;
            coef_valid_reg <= '0;
            row_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cw_en)
            begin
                coef_valid_reg[cw_addr] <= 1'b1;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (smp_start)
                    begin
                        state_reg    <= ST_RUN;
                        step_reg     <= STEP_CHECK;
                        sec_reg      <= '0;
                        last_sec_reg <= last_sec_start;
                        cbase_reg    <= '0;
                        flag_reg     <= 1'b0;
                        if (items.start_of_block)
                        begin
                            peak_reg      <= '0;
                            row_valid_reg <= '0;
                        end
                    end
                end
                ST_RUN:
                begin
                    if (step_reg == STEP_OUTPUT)
                        step_reg <= STEP_CHECK;
                    else
                        step_reg <= step_reg + 1'b1;
                    case (step_reg)
                        STEP_CHECK:
                        begin
                            if (overflow)
                            begin
                                peak_reg      <= '0;
                                row_valid_reg <= '0;
                                flag_reg      <= 1'b1;
                            end
                        end
                        STEP_CENTER:
                        begin
                            if (mac_mag > peak_reg)
                                peak_reg <= mac_mag;
                        end
                        STEP_OUTPUT:
                        begin
                            if (mac_mag > peak_reg)
                                peak_reg <= mac_mag;
                            row_valid_reg[sec_reg] <= 1'b1;
                            if (sec_reg == last_sec_reg)
                            begin
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                sec_reg   <= sec_reg + 1'b1;
                                cbase_reg <= cbase_reg + CADDR_W'(COEF_PER_SECTION);
                            end
                        end
                        default: ;
                    endcase
                end
                ST_DONE:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        coef_ok_reg <= coef_valid_reg[craddr];

        if (smp_start)
        begin
            x_reg <= sig_t'(items.sample_in) <<< IN_FRAC;
        end

        if (running && (step_reg == STEP_MUL_B0))
        begin
            // a cleared section reads as zero state
            if (row_valid_reg[sec_reg])
            begin
                d1_reg  <= row_rdata[4*DATA_W-1:3*DATA_W];
                d2_reg  <= row_rdata[3*DATA_W-1:2*DATA_W];
                yd1_reg <= row_rdata[2*DATA_W-1:DATA_W];
                yd2_reg <= row_rdata[DATA_W-1:0];
            end
            else
            begin
                d1_reg  <= '0;
                d2_reg  <= '0;
                yd1_reg <= '0;
                yd2_reg <= '0;
            end
        end

        if (running && (step_reg == STEP_CENTER))
        begin
            center_reg <= mac_result;
        end

        if (row_we)
        begin
            x_reg <= mac_result;
        end

        if (out_load)
        begin
            out_sample_reg <= out_sat;
            out_flag_reg   <= flag_reg;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.sample_out       = out_sample_reg;
    assign results.overflow_cleared = out_flag_reg;
endmodule

// ===== rtl/cbq_checker.sv =====
`include "cascaded_biquad_iir_filter_defines.svh"

module cbq_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               item_valid,
    input logic                               item_ready,
    input logic                               item_func,
    input logic                               result_valid,
    input logic                               result_ready,
    input logic signed [cbq_pkg::SAMPLE_W-1:0] sample_out,
    input logic                               overflow_cleared
);
    import cbq_pkg::*;

    `CBQ_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid, "result word dropped while stalled")
    `CBQ_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(sample_out) && $stable(overflow_cleared), "result word changed while stalled")
    `CBQ_ASSERT_NEXT(a_busy_after_sample, item_valid && item_ready && item_func == FUNC_SAMPLE, !item_ready, "sample word accepted but block not busy")
    `CBQ_ASSERT_NEXT(a_coef_no_result, item_valid && item_ready && item_func == FUNC_COEF && !result_valid, !result_valid, "coefficient word produced a result")
    `CBQ_ASSERT_SAME(a_idle_on_result, $rose(result_valid), item_ready, "result shown while still busy")
endmodule

bind cascaded_biquad_iir_filter cbq_checker u_cbq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (items.valid),
    .item_ready       (items.ready),
    .item_func        (items.func),
    .result_valid     (results.valid),
    .result_ready     (results.ready),
    .sample_out       (results.sample_out),
    .overflow_cleared (results.overflow_cleared)
);
